// ----- sv/mbcf_pkg.sv -----
// ----------------------------------------------------------------------------
// mbcf_pkg: shared definitions for the meter block check frame receiver
// Control characters, status codes and the result item layout.
// ----------------------------------------------------------------------------
package mbcf_pkg;

	// default longest reply, in bytes
	localparam int MAX_FRAME_DEF = 1024;

	// control characters of the line protocol
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_ETX = 8'h03;

	// input item kinds (carried on tuser)
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	// check modes
	localparam logic MODE_XOR = 1'b0;
	localparam logic MODE_SUM = 1'b1;

	// configuration register indexes
	localparam logic REG_START_BYTE = 1'b0;
	localparam logic REG_CHECK_MODE = 1'b1;

	// reset values of the configuration registers
	localparam logic [7:0] START_BYTE_RST = 8'h02;
	localparam logic       CHECK_MODE_RST = MODE_XOR;

	// reply status
	typedef enum logic [2:0] {
		STATUS_ACK   = 3'd0,
		STATUS_NAK   = 3'd1,
		STATUS_OK    = 3'd2,
		STATUS_BAD   = 3'd3,
		STATUS_EMPTY = 3'd4
	} status_t;

	// one result item
	typedef struct packed {
		logic [6:0]  check_computed;
		logic [7:0]  check_received;
		logic [10:0] frame_length;
		status_t     status;
	} result_t;

endpackage

// ----- sv/mbcf_frame_core.sv -----
// ----------------------------------------------------------------------------
// mbcf_frame_core: frame state and reply judgment
// Holds the running count, first byte, previous byte and block check of the
// reply in progress, and works out the result when a reply ends.
// ----------------------------------------------------------------------------
module mbcf_frame_core #(
	parameter int MAX_FRAME = mbcf_pkg::MAX_FRAME_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               op,
	input  logic [7:0]         rx_byte,
	input  logic [7:0]         start_byte,
	input  logic               check_mode,
	output logic               res_valid,
	output mbcf_pkg::result_t  res
);

	localparam int CW = $clog2(MAX_FRAME + 1);

	logic [CW-1:0] count_q;
	logic [7:0]    first_q;
	logic [7:0]    prev_q;
	logic [6:0]    accum_q;

	logic [CW-1:0] count_n;
	logic [7:0]    first_n;
	logic [6:0]    accum_n;
	logic          done;

	// judgment of an ended reply
	function automatic mbcf_pkg::result_t judge(input logic [CW-1:0] cnt,
			input logic [7:0] first, input logic [6:0] accum, input logic [7:0] last);
		mbcf_pkg::result_t r;
		r.check_computed = '0;
		r.frame_length   = 11'(cnt);
		r.check_received = (cnt == '0) ? 8'h00 : last;
		if (cnt == CW'(1) && first == mbcf_pkg::CH_ACK) begin
			r.status = mbcf_pkg::STATUS_ACK;
		end else if (cnt == CW'(1) && first == mbcf_pkg::CH_NAK) begin
			r.status = mbcf_pkg::STATUS_NAK;
		end else if (cnt < CW'(2)) begin
			r.status = mbcf_pkg::STATUS_EMPTY;
		end else begin
			r.check_computed = accum;
			r.status = (last == {1'b0, accum}) ? mbcf_pkg::STATUS_OK : mbcf_pkg::STATUS_BAD;
		end
		return r;
	endfunction

	// next state for a received byte; the check runs one byte behind
	always_comb begin
		count_n = count_q + CW'(1);
		first_n = (count_q == '0) ? rx_byte : first_q;
		accum_n = accum_q;
		if (count_n >= CW'(3)) begin
			if (check_mode == mbcf_pkg::MODE_SUM) begin
				accum_n = accum_q + prev_q[6:0];
			end else begin
				accum_n = accum_q ^ prev_q[6:0];
			end
		end
		done = 1'b0;
		if (count_n == CW'(1) && (rx_byte == mbcf_pkg::CH_ACK || rx_byte == mbcf_pkg::CH_NAK))
			done = 1'b1;
		if (count_n > CW'(3) && first_q == start_byte && prev_q == mbcf_pkg::CH_ETX)
			done = 1'b1;
		if (count_n >= CW'(MAX_FRAME))
			done = 1'b1;
	end

	// result of this item
	always_comb begin
		if (op == mbcf_pkg::OP_TIMEOUT) begin
			res_valid = en;
			res       = judge(count_q, first_q, accum_q, prev_q);
		end else begin
			res_valid = en & done;
			res       = judge(count_n, first_n, accum_n, rx_byte);
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			first_q <= '0;
			prev_q  <= '0;
			accum_q <= '0;
		end else if (en) begin
			if (op == mbcf_pkg::OP_TIMEOUT || done) begin
				count_q <= '0;
				first_q <= '0;
				prev_q  <= '0;
				accum_q <= '0;
			end else begin
				count_q <= count_n;
				first_q <= first_n;
				prev_q  <= rx_byte;
				accum_q <= accum_n;
			end
		end
	end

endmodule

// ----- sv/meter_block_check_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// meter_block_check_frame_receiver_unit: meter reply framing and block check
// Ends replies on ACK/NAK, start byte plus ETX, timeout or length limit, and
// reports status, length and the received and computed block check.
// ----------------------------------------------------------------------------
// One item per clock: a received byte or timeout is taken into an input
// register, judged from there and its result, if any, is registered in the
// output register, so the sustained rate is one item every cycle while the
// output side takes results. The frame state update in the judging stage
// sets that rate. A byte that does not end a reply produces no result; a
// timeout always produces one. The block check covers every byte but the
// first and the last, as a 7-bit XOR or a 7-bit sum per check_mode.
module meter_block_check_frame_receiver_unit #(
	parameter int MAX_FRAME = mbcf_pkg::MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] op
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [2:0] status, [13:3] frame_length,
	                               // [21:14] check_received, [28:22] check_computed
);

	logic [7:0] start_byte_q;
	logic       check_mode_q;

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       advance;

	logic               res_valid;
	mbcf_pkg::result_t  res;
	logic               valid_s2;
	mbcf_pkg::result_t  res_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= mbcf_pkg::START_BYTE_RST;
			check_mode_q <= mbcf_pkg::CHECK_MODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mbcf_pkg::REG_START_BYTE: start_byte_q <= cfg_wdata;
				mbcf_pkg::REG_CHECK_MODE: check_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// flow control
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// frame state and judgment
	mbcf_frame_core #(
		.MAX_FRAME (MAX_FRAME)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.op         (op_s1),
		.rx_byte    (byte_s1),
		.start_byte (start_byte_q),
		.check_mode (check_mode_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, res_s2};

	// a timeout always yields a result
	a_timeout_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == mbcf_pkg::OP_TIMEOUT |=> m_tvalid)
		else $error("timeout item gave no result");

	// a judged check needs at least two bytes
	a_check_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_s2.status == mbcf_pkg::STATUS_OK ||
			res_s2.status == mbcf_pkg::STATUS_BAD) |-> res_s2.frame_length >= 11'd2)
		else $error("check judged on a reply shorter than two bytes");

	// ack and nak are lone bytes with no computed check
	a_ack_nak: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_s2.status == mbcf_pkg::STATUS_ACK ||
			res_s2.status == mbcf_pkg::STATUS_NAK)
		|-> res_s2.frame_length == 11'd1 && res_s2.check_computed == 7'd0)
		else $error("ack or nak result with wrong length or check");

endmodule
